// ----- rtl/hpm_pkg.sv -----
`timescale 1ns / 1ps
// hpm_pkg: shared constants, types and codes for the hot page migration remapper.
// No dependencies; the interfaces, front, back, top level and testbench import it.
package hpm_pkg;

   // Address geometry
   localparam int ADDR_BITS        = 24;
   localparam int PAGE_BITS        = 12;
   localparam int MODULE_ADDR_BITS = 22;
   localparam int PAGE_NUM_BITS    = ADDR_BITS - PAGE_BITS;
   localparam int MODULE_BITS      = ADDR_BITS - MODULE_ADDR_BITS;
   localparam int MOD_PAGE_BITS    = MODULE_ADDR_BITS - PAGE_BITS;
   localparam int NUM_PAGES        = 1 << PAGE_NUM_BITS;
   localparam int MOD_PAGES        = 1 << MOD_PAGE_BITS;

   localparam int TICK_BITS  = 16;
   localparam int COUNT_BITS = 32;
   localparam int CSR_BITS   = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_EPOCH_LIMIT = 1'b0,
      CSR_THRESHOLD   = 1'b1
   } csr_index_type;

   typedef logic [PAGE_NUM_BITS-1:0] page_type;

   // One classified request in the queue between front and back
   typedef struct packed {
      logic                 is_tick;
      page_type             page;
      logic [PAGE_BITS-1:0] offset;
      logic                 is_write;
      logic [TICK_BITS-1:0] ticks;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_head_type;

   typedef struct packed {
      logic pop;
      logic init_done;
   } back_ctl_type;

   typedef struct packed {
      logic [CSR_BITS-1:0] epoch_limit;
      logic [CSR_BITS-1:0] threshold;
   } cfg_type;

endpackage

// ----- rtl/hpm_ifaces.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready with payload).
// Depends on hpm_pkg.
interface hpm_req_if;
   import hpm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [ADDR_BITS-1:0] address;
   logic                 is_write;
   logic [TICK_BITS-1:0] elapsed_ticks;
   modport source (output valid, mode, address, is_write, elapsed_ticks, input ready);
   modport sink (input valid, mode, address, is_write, elapsed_ticks, output ready);
endinterface

interface hpm_rsp_if;
   import hpm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [ADDR_BITS-1:0]   translated_address;
   logic [MODULE_BITS-1:0] module_number;
   logic                   write_flag;
   modport source (output valid, translated_address, module_number, write_flag, input ready);
   modport sink (input valid, translated_address, module_number, write_flag, output ready);
endinterface

// ----- rtl/hpm_ram.sv -----
`timescale 1ns / 1ps
// hpm_ram: generic RAM, one write port, two registered read ports.
// No dependencies.
module hpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;
endmodule

// ----- rtl/hpm_front.sv -----
`timescale 1ns / 1ps
// hpm_front: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on hpm_pkg and hpm_req_if.
module hpm_front (
   input  logic                   clock,
   input  logic                   reset,
   hpm_req_if.sink                req_ch,
   input  hpm_pkg::back_ctl_type  back_ctl,
   output hpm_pkg::queue_head_type head
);
   import hpm_pkg::*;

   op_type     op_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   op_type     new_op;

   // Requests are taken only once the tables are initialized
   assign req_ch.ready = back_ctl.init_done && (cnt_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;

   // Classify into a queue entry
   always_comb begin
      new_op.is_tick  = req_ch.mode;
      new_op.page     = req_ch.address[ADDR_BITS-1:PAGE_BITS];
      new_op.offset   = req_ch.address[PAGE_BITS-1:0];
      new_op.is_write = req_ch.is_write;
      new_op.ticks    = req_ch.elapsed_ticks;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ back_ctl.pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, back_ctl.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff] <= new_op;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.op    = op_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      back_ctl.pop |-> cnt_ff != 2'd0) else $error("pop from empty queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_no_push_init: assert property (@(posedge clock) disable iff (reset)
      !back_ctl.init_done |-> !push) else $error("request taken during table init");
`endif
endmodule

// ----- rtl/hpm_back.sv -----
`timescale 1ns / 1ps
// hpm_back: table init, translation and counting, epoch tracking and the migration sweep.
// Depends on hpm_pkg, hpm_rsp_if and hpm_ram.
module hpm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  hpm_pkg::cfg_type        cfg,
   input  hpm_pkg::queue_head_type head,
   output hpm_pkg::back_ctl_type   back_ctl,
   hpm_rsp_if.source               rsp_ch
);
   import hpm_pkg::*;

   typedef enum logic [5:0] {
      S_INIT  = 6'b000001,
      S_IDLE  = 6'b000010,
      S_ACC   = 6'b000100,
      S_SWRD  = 6'b001000,
      S_SWCHK = 6'b010000,
      S_SWWR2 = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   page_type               idx_ff, idx_in;
   logic [COUNT_BITS-1:0]  epoch_ff, epoch_in;
   page_type               cur_page_ff, cur_page_in;
   logic [PAGE_BITS-1:0]   cur_off_ff, cur_off_in;
   logic                   cur_wr_ff, cur_wr_in;
   page_type               tmp_ff, tmp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]   rsp_addr_ff, rsp_addr_in;
   logic                   rsp_wr_ff, rsp_wr_in;

   logic                   map_we, cnt_we;
   page_type               map_waddr, map_wdata, map_ra, map_rb, map_da, map_db;
   page_type               cnt_waddr, cnt_ra;
   logic [COUNT_BITS-1:0]  cnt_wdata, cnt_d;
   page_type               low_idx;
   logic                   slot_free;
   logic [COUNT_BITS:0]    epoch_sum;

   hpm_ram #(.WIDTH(PAGE_NUM_BITS), .DEPTH(NUM_PAGES)) u_map (
      .clock(clock), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
      .raddr_a(map_ra), .raddr_b(map_rb), .rdata_a(map_da), .rdata_b(map_db)
   );

   hpm_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_PAGES)) u_cnt (
      .clock(clock), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
      .raddr_a(cnt_ra), .raddr_b(cnt_ra), .rdata_a(cnt_d), .rdata_b()
   );

   assign low_idx   = idx_ff - page_type'(MOD_PAGES);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign epoch_sum = {1'b0, epoch_ff} + (COUNT_BITS+1)'(head.op.ticks);

   // Read addresses: the sweep walks idx, otherwise the page being served
   always_comb begin
      if ((state_ff == S_SWRD) || (state_ff == S_SWCHK) || (state_ff == S_SWWR2)) begin
         map_ra = idx_ff;
         map_rb = low_idx;
         cnt_ra = idx_ff;
      end else if (state_ff == S_IDLE) begin
         map_ra = head.op.page;
         map_rb = head.op.page;
         cnt_ra = head.op.page;
      end else begin
         map_ra = cur_page_ff;
         map_rb = cur_page_ff;
         cnt_ra = cur_page_ff;
      end
   end

   // Main sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      epoch_in     = epoch_ff;
      cur_page_in  = cur_page_ff;
      cur_off_in   = cur_off_ff;
      cur_wr_in    = cur_wr_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_wr_in    = rsp_wr_ff;
      map_we       = 1'b0;
      map_waddr    = idx_ff;
      map_wdata    = idx_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = idx_ff;
      cnt_wdata    = '0;
      back_ctl.pop       = 1'b0;
      back_ctl.init_done = (state_ff != S_INIT);

      case (state_ff)
         S_INIT: begin
            map_we = 1'b1;
            cnt_we = 1'b1;
            idx_in = idx_ff + page_type'(1);
            if (idx_ff == page_type'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head.valid) begin
               back_ctl.pop = 1'b1;
               if (head.op.is_tick) begin
                  epoch_in = epoch_sum[COUNT_BITS] ? COUNT_MAX : epoch_sum[COUNT_BITS-1:0];
               end else begin
                  cur_page_in = head.op.page;
                  cur_off_in  = head.op.offset;
                  cur_wr_in   = head.op.is_write;
                  state_in    = S_ACC;
               end
            end
         end
         S_ACC: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = {map_da, cur_off_ff};
               rsp_wr_in    = cur_wr_ff;
               cnt_we       = 1'b1;
               cnt_waddr    = cur_page_ff;
               cnt_wdata    = (cnt_d == COUNT_MAX) ? cnt_d : cnt_d + COUNT_BITS'(1);
               if (epoch_ff > cfg.epoch_limit) begin
                  epoch_in = '0;
                  idx_in   = '0;
                  state_in = S_SWRD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SWRD: begin
            state_in = S_SWCHK;
         end
         S_SWCHK: begin
            // Clear the count; a hot page outside module 0 swaps with the page one module below
            cnt_we = 1'b1;
            if ((cnt_d > cfg.threshold) &&
                (idx_ff[PAGE_NUM_BITS-1:MOD_PAGE_BITS] != '0)) begin
               map_we    = 1'b1;
               map_wdata = map_db;
               tmp_in    = map_da;
               state_in  = S_SWWR2;
            end else if (idx_ff == page_type'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + page_type'(1);
               state_in = S_SWRD;
            end
         end
         S_SWWR2: begin
            map_we    = 1'b1;
            map_waddr = low_idx;
            map_wdata = tmp_ff;
            if (idx_ff == page_type'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + page_type'(1);
               state_in = S_SWRD;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_page_ff <= cur_page_in;
      cur_off_ff  <= cur_off_in;
      cur_wr_ff   <= cur_wr_in;
      tmp_ff      <= tmp_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_wr_ff   <= rsp_wr_in;
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.translated_address = rsp_addr_ff;
   assign rsp_ch.module_number      = rsp_addr_ff[ADDR_BITS-1:MODULE_ADDR_BITS];
   assign rsp_ch.write_flag         = rsp_wr_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_acc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_ACC)) else $error("response without access");
   a_map_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_ACC || state_ff == S_SWRD) |-> !map_we)
      else $error("map written outside init or sweep");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      back_ctl.pop |-> state_ff == S_IDLE) else $error("queue popped while busy");
   a_swap_upper: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWWR2 |-> idx_ff[PAGE_NUM_BITS-1:MOD_PAGE_BITS] != '0)
      else $error("swap issued from module 0");
`endif
endmodule

// ----- rtl/hot_page_migration_remapper.sv -----
`timescale 1ns / 1ps
// Top level of the hot page migration remapper: config registers, front and back.
// Depends on hpm_pkg, hpm_ifaces, hpm_front and hpm_back.
//
// After reset the block writes the identity page map and clears the access counts, one
// page per cycle, and takes no request then. A tick request ends in the idle state; an
// access reads map and count, then sends the response and writes the count back in the
// access state, waiting while the response register is still held. An access that finds
// the epoch counter past the epoch limit starts a sweep over all 4096 pages: a read and a
// check state per page and a second map write for a page that migrates, as the map memory
// has a single write port. A two-entry queue takes requests while the back end is busy.
module hot_page_migration_remapper (
   input  logic                         clock,
   input  logic                         reset,
   hpm_req_if.sink                      req_ch,
   hpm_rsp_if.source                    rsp_ch,
   input  logic                         csr_write_enable,
   input  hpm_pkg::csr_index_type       csr_index,
   input  logic [hpm_pkg::CSR_BITS-1:0] csr_write_data
);
   import hpm_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   queue_head_type head;
   back_ctl_type   back_ctl;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_EPOCH_LIMIT: cfg_in.epoch_limit = csr_write_data;
            CSR_THRESHOLD:   cfg_in.threshold   = csr_write_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.epoch_limit <= CSR_BITS'(100000);
         cfg_ff.threshold   <= CSR_BITS'(16);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hpm_front u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch), .back_ctl(back_ctl), .head(head)
   );

   hpm_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .head(head), .back_ctl(back_ctl),
      .rsp_ch(rsp_ch)
   );
endmodule

// ----- sim/hot_page_migration_remapper_tb.sv -----
`timescale 1ns / 1ps
// Testbench for hot_page_migration_remapper: random and directed access/tick requests,
// checked against an in-bench page map, access counter and epoch sweep predictor.
// Depends on hpm_pkg, hpm_ifaces and the RTL of the block.

// Predicts translations and holds the responses still owed by the block
class remap_scoreboard;
   logic [hpm_pkg::PAGE_NUM_BITS-1:0] page_map [hpm_pkg::NUM_PAGES];
   logic [31:0] access_count [hpm_pkg::NUM_PAGES];
   logic [31:0] epoch_ticks;
   logic [31:0] epoch_limit;
   logic [31:0] threshold;
   logic [26:0] owed [$];   // {translated_address, module_number, write_flag}
   int          errors;
   int          responses;

   function new();
      for (int i = 0; i < hpm_pkg::NUM_PAGES; i++) begin
         page_map[i] = hpm_pkg::PAGE_NUM_BITS'(i);
         access_count[i] = '0;
      end
      epoch_ticks = '0;
      epoch_limit = 32'd100000;
      threshold = 32'd16;
      errors = 0;
      responses = 0;
   endfunction

   function void write_reg(hpm_pkg::csr_index_type idx, logic [31:0] value);
      if (idx == hpm_pkg::CSR_EPOCH_LIMIT) epoch_limit = value;
      else threshold = value;
   endfunction

   // Migrate hot pages one module down, ascending page order, then clear counts
   function void run_sweep();
      logic [hpm_pkg::PAGE_NUM_BITS-1:0] t;
      for (int i = hpm_pkg::MOD_PAGES; i < hpm_pkg::NUM_PAGES; i++) begin
         if (access_count[i] > threshold) begin
            t = page_map[i];
            page_map[i] = page_map[i - hpm_pkg::MOD_PAGES];
            page_map[i - hpm_pkg::MOD_PAGES] = t;
         end
      end
      for (int i = 0; i < hpm_pkg::NUM_PAGES; i++) access_count[i] = '0;
   endfunction

   function void note_request(logic mode, logic [23:0] addr, logic wr, logic [15:0] ticks);
      logic [32:0] sum;
      logic [11:0] page;
      logic [23:0] phys;
      if (mode) begin
         sum = {1'b0, epoch_ticks} + ticks;
         epoch_ticks = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         return;
      end
      page = addr[23:12];
      phys = {page_map[page], addr[11:0]};
      owed.push_back({phys, phys[23:22], wr});
      if (access_count[page] != 32'hFFFF_FFFF) access_count[page]++;
      if (epoch_ticks > epoch_limit) begin
         epoch_ticks = '0;
         run_sweep();
      end
   endfunction

   function void check_response(logic [23:0] addr, logic [1:0] modn, logic wr);
      logic [26:0] e;
      responses++;
      if (owed.size() == 0) begin
         $error("unexpected response address %h", addr);
         errors++;
         return;
      end
      e = owed.pop_front();
      if (addr !== e[26:3]) begin
         $error("translated_address expected %h actual %h", e[26:3], addr);
         errors++;
      end
      if (modn !== e[2:1]) begin
         $error("module_number expected %0d actual %0d", e[2:1], modn);
         errors++;
      end
      if (wr !== e[0]) begin
         $error("write_flag expected %0d actual %0d", e[0], wr);
         errors++;
      end
   endfunction
endclass

module hot_page_migration_remapper_tb;
   import hpm_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_EPOCH_LIMIT;
   logic [31:0]   csr_write_data = '0;
   logic          stall_enable = 1'b1;

   hpm_req_if req_ch ();
   hpm_rsp_if rsp_ch ();

   remap_scoreboard board = new();

   hot_page_migration_remapper dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = 1'b0;
      req_ch.address = '0;
      req_ch.is_write = 1'b0;
      req_ch.elapsed_ticks = '0;
      rsp_ch.ready = 1'b0;
   end

   // Response side: random ready bursts, checked at the edge
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         if (stall_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_response(rsp_ch.translated_address, rsp_ch.module_number,
                              rsp_ch.write_flag);
   end

   // Send one request and wait for its acceptance
   task automatic send_request(logic mode, logic [23:0] addr, logic wr, logic [15:0] ticks);
      int gap;
      if (stall_enable && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 16);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.address <= addr;
      req_ch.is_write <= wr;
      req_ch.elapsed_ticks <= ticks;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(mode, addr, wr, ticks);
   endtask

   // Wait for outstanding responses, then let a sweep settle before the next write
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.owed.size() != 0) @(posedge clock);
      repeat (20000) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.write_reg(idx, value);
   endtask

   // Mostly hot-page traffic on a few pages, with ticks to close epochs
   task automatic random_phase(int count, int hot_span);
      logic [11:0] page;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 2)
            send_request(1'b1, 24'($urandom), 1'($urandom), $urandom_range(0, 3) == 0 ?
                         16'hFFFF : 16'($urandom_range(0, 65535)));
         else begin
            if ($urandom_range(0, 4) == 0) page = 12'($urandom);
            else page = {2'($urandom_range(0, 3)), 10'($urandom_range(0, hot_span))};
            send_request(1'b0, {page, 12'($urandom)}, 1'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, both operations, saturation-size ticks
      send_request(1'b0, 24'h000000, 1'b0, 16'hFFFF);
      send_request(1'b0, 24'hFFFFFF, 1'b1, 16'h0000);
      send_request(1'b0, 24'h400FFF, 1'b1, 16'h1234);
      send_request(1'b1, 24'hFFFFFF, 1'b1, 16'h0000);
      send_request(1'b1, 24'h000000, 1'b0, 16'hFFFF);
      send_request(1'b1, 24'hABCDEF, 1'b1, 16'hFFFF);
      for (int n = 0; n < 4; n++) send_request(1'b0, 24'h800123, n[0], 16'h0);
      drain();

      // Zero threshold and short epoch: every touched page outside module 0 migrates, chained swaps
      write_reg(CSR_THRESHOLD, 32'd0);
      write_reg(CSR_EPOCH_LIMIT, 32'd0);
      send_request(1'b0, 24'hC00010, 1'b0, 16'h0);
      send_request(1'b0, 24'h800020, 1'b1, 16'h0);
      send_request(1'b0, 24'h400030, 1'b0, 16'h0);
      send_request(1'b0, 24'h000040, 1'b1, 16'h0);
      send_request(1'b1, 24'h0, 1'b0, 16'd1);
      send_request(1'b0, 24'hC00050, 1'b0, 16'h0);
      send_request(1'b0, 24'hC00060, 1'b0, 16'h0);
      send_request(1'b0, 24'h800070, 1'b0, 16'h0);
      send_request(1'b0, 24'h000080, 1'b0, 16'h0);
      drain();

      write_reg(CSR_THRESHOLD, 32'd3);
      write_reg(CSR_EPOCH_LIMIT, 32'd150000);
      random_phase(450, 15);
      drain();

      // Maximum registers: no sweep can fire
      write_reg(CSR_THRESHOLD, 32'hFFFF_FFFF);
      write_reg(CSR_EPOCH_LIMIT, 32'hFFFF_FFFF);
      random_phase(200, 1023);
      drain();

      write_reg(CSR_THRESHOLD, 32'd1);
      write_reg(CSR_EPOCH_LIMIT, 32'd60000);
      random_phase(450, 7);
      drain();

      // Final stretch without idling
      stall_enable = 1'b0;
      write_reg(CSR_THRESHOLD, 32'd16);
      write_reg(CSR_EPOCH_LIMIT, 32'd100000);
      random_phase(280, 31);
      req_ch.valid <= 1'b0;

      while (board.owed.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.owed.size() == 0)
         $display("PASS hot_page_migration_remapper");
      else
         $display("FAIL hot_page_migration_remapper");
      $finish;
   end

   initial begin
      #1s;
      $display("FAIL hot_page_migration_remapper");
      $finish;
   end

endmodule
